// ----- hdl/assert_macros.svh -----
// Assertion macros for the port-level checker swlsq_check.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/swlsq_pkg.sv -----
// Shared types and constants for the sliding-window least-squares slope block.
// No dependencies; used by the top level, its checker and the testbench.
package swlsq_pkg;

	localparam int WINDOW_DEF = 21;

	// Fixed widths of samples, running sums and the slope arithmetic.
	localparam int X_W     = 16;
	localparam int Y_W     = 24;
	localparam int SX_W    = 21;
	localparam int SY_W    = 29;
	localparam int SXY_W   = 45;
	localparam int SXX_W   = 36;
	localparam int NUM_W   = 51;
	localparam int DEN_W   = 42;
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 30;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int LO_W    = 24;
	localparam int FRAC_W  = 16;
	localparam int Q_W     = 33;
	localparam int SLOPE_W = 32;

	localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
	localparam logic [SLOPE_W-1:0] SLOPE_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [X_W-1:0] x_value;
		logic signed [Y_W-1:0] y_value;
		logic                  new_profile;
	} in_t;

	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope_out;
		logic                      degenerate;
		logic                      saturated;
	} out_t;

endpackage

// ----- hdl/sliding_window_lsq_slope.sv -----
// Sliding-window least-squares slope: window store, running sums, a shared 25x30
// multiply-accumulate unit and a 33-step restoring divider.
// A result is produced for an input beat only with a full window; a zero denominator or
// an out-of-range slope skips the divider. A new input beat is taken only once the block
// is idle again after the last one (accept, load, multiply slots, check, divide steps,
// result), later while a result beat waits. Async reset.
module sliding_window_lsq_slope
	import swlsq_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int ACC_W  = NUM_W;
	localparam int HI_W   = NUM_W - FRAC_W - 1;
	localparam int CNT_W  = $clog2(Q_W);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_CHK, S_DIV, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		MS_XY, MS_OXY, MS_XX, MS_OXX, MS_SXSY, MS_SXSX,
		MS_NXY_LO, MS_NXY_HI, MS_NXX_LO, MS_NXX_HI, MS_DONE
	} mstep_t;

	state_t state_q;
	mstep_t step_q, tag_s1;
	logic   pv_s1;

	logic signed [X_W-1:0] x_mem [WINDOW];
	logic signed [Y_W-1:0] y_mem [WINDOW];

	logic signed [X_W-1:0]   x_q, ox_q;
	logic signed [Y_W-1:0]   y_q, oy_q;
	logic                    full_q, emit_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [FILL_W-1:0]       fill_q;
	logic signed [SX_W-1:0]  sum_x_q;
	logic signed [SY_W-1:0]  sum_y_q;
	logic signed [SXY_W-1:0] sum_xy_q;
	logic signed [SXX_W-1:0] sum_xx_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [DEN_W-1:0] den_q;
	logic signed [PROD_W-1:0] p_s1;

	logic                 neg_q, degen_q, ovf_q;
	logic [DEN_W-1:0]     rem_q;
	logic [Q_W-1:0]       dvd_q, quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	out_t                 out_q;

	logic                     accept;
	logic [SLOT_W-1:0]        slot_eff;
	logic [FILL_W-1:0]        fill_eff;
	logic signed [X_W-1:0]    oxm;
	logic signed [Y_W-1:0]    oym;
	logic signed [MUL_A_W-1:0] opa;
	logic signed [MUL_B_W-1:0] opb;
	logic signed [ACC_W-1:0]  acc_cur, acc_add, acc_new;
	logic                     acc_sub;
	logic [NUM_W-1:0]         mag;
	logic [HI_W-1:0]          mag_hi;
	logic [DEN_W:0]           rem_sh;
	logic                     rem_ge;
	logic                     pos_sat, neg_sat;
	logic [SLOPE_W-1:0]       slope_res;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign slot_eff = in_data.new_profile ? '0 : slot_q;
	assign fill_eff = in_data.new_profile ? '0 : fill_q;

	// Old pair counts only once the window has wrapped.
	assign oxm = full_q ? ox_q : '0;
	assign oym = full_q ? oy_q : '0;

	// Window store: write the entering pair, read the leaving one at the same slot.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_mem[slot_eff] <= in_data.x_value;
			y_mem[slot_eff] <= in_data.y_value;
			ox_q            <= x_mem[slot_eff];
			oy_q            <= y_mem[slot_eff];
		end
	end

	// Operand select for the shared multiplier.
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (step_q)
			MS_XY: begin
				opa = MUL_A_W'(x_q);
				opb = MUL_B_W'(y_q);
			end
			MS_OXY: begin
				opa = MUL_A_W'(oxm);
				opb = MUL_B_W'(oym);
			end
			MS_XX: begin
				opa = MUL_A_W'(x_q);
				opb = MUL_B_W'(x_q);
			end
			MS_OXX: begin
				opa = MUL_A_W'(oxm);
				opb = MUL_B_W'(oxm);
			end
			MS_SXSY: begin
				opa = MUL_A_W'(sum_x_q);
				opb = MUL_B_W'(sum_y_q);
			end
			MS_SXSX: begin
				opa = MUL_A_W'(sum_x_q);
				opb = MUL_B_W'(sum_x_q);
			end
			MS_NXY_LO: begin
				opa = MUL_A_W'(WINDOW);
				opb = MUL_B_W'({1'b0, sum_xy_q[LO_W-1:0]});
			end
			MS_NXY_HI: begin
				opa = MUL_A_W'(WINDOW);
				opb = MUL_B_W'($signed(sum_xy_q[SXY_W-1:LO_W]));
			end
			MS_NXX_LO: begin
				opa = MUL_A_W'(WINDOW);
				opb = MUL_B_W'({1'b0, sum_xx_q[LO_W-1:0]});
			end
			MS_NXX_HI: begin
				opa = MUL_A_W'(WINDOW);
				opb = MUL_B_W'($signed(sum_xx_q[SXX_W-1:LO_W]));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// Shared accumulate adder: target, sign and shift follow the product's tag.
	always_comb begin
		acc_cur = '0;
		acc_sub = 1'b0;
		acc_add = ACC_W'(p_s1);
		unique case (tag_s1)
			MS_XY:     acc_cur = ACC_W'(sum_xy_q);
			MS_OXY: begin
				acc_cur = ACC_W'(sum_xy_q);
				acc_sub = 1'b1;
			end
			MS_XX:     acc_cur = ACC_W'(sum_xx_q);
			MS_OXX: begin
				acc_cur = ACC_W'(sum_xx_q);
				acc_sub = 1'b1;
			end
			MS_SXSY: begin
				acc_cur = num_q;
				acc_sub = 1'b1;
			end
			MS_SXSX: begin
				acc_cur = ACC_W'(den_q);
				acc_sub = 1'b1;
			end
			MS_NXY_LO: acc_cur = num_q;
			MS_NXY_HI: begin
				acc_cur = num_q;
				acc_add = ACC_W'(p_s1) <<< LO_W;
			end
			MS_NXX_LO: acc_cur = ACC_W'(den_q);
			MS_NXX_HI: begin
				acc_cur = ACC_W'(den_q);
				acc_add = ACC_W'(p_s1) <<< LO_W;
			end
			default:   acc_cur = '0;
		endcase
		acc_new = acc_sub ? (acc_cur - acc_add) : (acc_cur + acc_add);
	end

	// Divider datapath and result formatting.
	assign mag    = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign mag_hi = mag[NUM_W-1:FRAC_W+1];
	assign rem_sh = {rem_q, dvd_q[Q_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	assign pos_sat = quo_q[Q_W-1] | quo_q[Q_W-2];
	assign neg_sat = quo_q[Q_W-1] | (quo_q[Q_W-2] & (|quo_q[Q_W-3:0]));

	always_comb begin
		if (neg_q) begin
			slope_res = (0 - quo_q[SLOPE_W-1:0]);
		end else begin
			slope_res = quo_q[SLOPE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= MS_XY;
			tag_s1      <= MS_XY;
			pv_s1       <= 1'b0;
			p_s1        <= '0;
			x_q         <= '0;
			y_q         <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			full_q      <= 1'b0;
			emit_q      <= 1'b0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_xy_q    <= '0;
			sum_xx_q    <= '0;
			num_q       <= '0;
			den_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			degen_q     <= 1'b0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
		end else begin
			// S_FIN either holds the beat or replaces it, so it never clears here.
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						x_q    <= in_data.x_value;
						y_q    <= in_data.y_value;
						full_q <= (fill_eff >= FILL_W'(WINDOW));
						emit_q <= (fill_eff >= FILL_W'(WINDOW - 1));
						slot_q <= (slot_eff == SLOT_W'(WINDOW - 1)) ? '0 : slot_eff + 1'b1;
						if (fill_eff < FILL_W'(WINDOW)) begin
							fill_q <= fill_eff + 1'b1;
						end else begin
							fill_q <= fill_eff;
						end
						if (in_data.new_profile) begin
							sum_x_q  <= '0;
							sum_y_q  <= '0;
							sum_xy_q <= '0;
							sum_xx_q <= '0;
						end
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					sum_x_q <= sum_x_q + SX_W'(x_q) - SX_W'(oxm);
					sum_y_q <= sum_y_q + SY_W'(y_q) - SY_W'(oym);
					num_q   <= '0;
					den_q   <= '0;
					step_q  <= MS_XY;
					state_q <= S_MUL;
				end
				S_MUL: begin
					// Issue one product a cycle; fold the previous one in.
					if (step_q != MS_DONE) begin
						p_s1   <= opa * opb;
						tag_s1 <= step_q;
						pv_s1  <= 1'b1;
						step_q <= mstep_t'(step_q + 4'd1);
					end else begin
						pv_s1   <= 1'b0;
						state_q <= emit_q ? S_CHK : S_IDLE;
					end
					if (pv_s1) begin
						unique case (tag_s1)
							MS_XY, MS_OXY:   sum_xy_q <= SXY_W'(acc_new);
							MS_XX, MS_OXX:   sum_xx_q <= SXX_W'(acc_new);
							MS_SXSY, MS_NXY_LO, MS_NXY_HI: num_q <= acc_new;
							MS_SXSX, MS_NXX_LO, MS_NXX_HI: den_q <= DEN_W'(acc_new);
							default: ;
						endcase
					end
				end
				S_CHK: begin
					neg_q   <= num_q[NUM_W-1];
					degen_q <= 1'b0;
					ovf_q   <= 1'b0;
					priority if (den_q[DEN_W-1] || (den_q == '0)) begin
						degen_q <= 1'b1;
						state_q <= S_FIN;
					end else if (DEN_W'(mag_hi) >= $unsigned(den_q)) begin
						// Quotient would not fit in 33 bits: clamp without dividing.
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						rem_q   <= DEN_W'(mag_hi);
						dvd_q   <= {mag[FRAC_W:0], {FRAC_W{1'b0}}};
						quo_q   <= '0;
						cnt_q   <= CNT_W'(Q_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
					dvd_q <= {dvd_q[Q_W-2:0], 1'b0};
					quo_q <= {quo_q[Q_W-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Hold until the previous result beat has gone.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						priority if (degen_q) begin
							out_q.slope_out  <= '0;
							out_q.degenerate <= 1'b1;
							out_q.saturated  <= 1'b0;
						end else if (ovf_q || (neg_q ? neg_sat : pos_sat)) begin
							out_q.slope_out  <= neg_q ? SLOPE_MIN : SLOPE_MAX;
							out_q.degenerate <= 1'b0;
							out_q.saturated  <= 1'b1;
						end else begin
							out_q.slope_out  <= slope_res;
							out_q.degenerate <= 1'b0;
							out_q.saturated  <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/swlsq_check.sv -----
// Port-level checker for sliding_window_lsq_slope, bound to the top level.
// Depends on swlsq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swlsq_check
	import swlsq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped before accept")
	`ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result beat changed while stalled")
	`ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while previous item in work")
	`ASSERT_NOW(a_degen_zero, out_valid && out_data.degenerate, (out_data.slope_out == '0) && !out_data.saturated, "degenerate result not zero")
	`ASSERT_NOW(a_sat_clamp, out_valid && out_data.saturated, (out_data.slope_out == SLOPE_MAX) || (out_data.slope_out == SLOPE_MIN), "saturated result not at a limit")

endmodule

bind sliding_window_lsq_slope swlsq_check u_swlsq_check (.*);

// ----- tb/sv/swlsq_checker.sv -----
`timescale 1ns / 100ps
// Checker for sliding_window_lsq_slope: tracks the sample window from the input
// beats, predicts each slope result and compares it with the output beats.
// Depends on swlsq_pkg for the payload types and widths.
module swlsq_checker
	import swlsq_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   errors,
	output int   pending,
	output int   results,
	output int   degenerate_cnt,
	output int   saturated_cnt
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic signed [X_W-1:0]   hist_x [WINDOW];
	logic signed [Y_W-1:0]   hist_y [WINDOW];
	logic signed [SX_W-1:0]  run_x;
	logic signed [SY_W-1:0]  run_y;
	logic signed [SXY_W-1:0] run_xy;
	logic signed [SXX_W-1:0] run_xx;
	logic [SLOT_W-1:0]       next_slot;
	int                      depth;
	out_t                    slope_due [$];

	function automatic void clear_sums();
		run_x = '0;
		run_y = '0;
		run_xy = '0;
		run_xx = '0;
		next_slot = '0;
		depth = 0;
	endfunction

	// Take one sample into the window; queue a slope once the window is full.
	function automatic void advance_window_slope(in_t beat);
		longint              num, den;
		longint unsigned     mag, dmag, quo, rem, fixed;
		logic [SLOPE_W-1:0]  lo;
		bit                  neg, sat;
		out_t                r;
		if (beat.new_profile)
			clear_sums();
		// drop the pair leaving the window
		if (depth >= WINDOW) begin
			run_x = SX_W'(longint'(run_x) - longint'(hist_x[next_slot]));
			run_y = SY_W'(longint'(run_y) - longint'(hist_y[next_slot]));
			run_xy = SXY_W'(longint'(run_xy)
				- longint'(hist_x[next_slot]) * longint'(hist_y[next_slot]));
			run_xx = SXX_W'(longint'(run_xx)
				- longint'(hist_x[next_slot]) * longint'(hist_x[next_slot]));
		end
		run_x = SX_W'(longint'(run_x) + longint'(beat.x_value));
		run_y = SY_W'(longint'(run_y) + longint'(beat.y_value));
		run_xy = SXY_W'(longint'(run_xy) + longint'(beat.x_value) * longint'(beat.y_value));
		run_xx = SXX_W'(longint'(run_xx) + longint'(beat.x_value) * longint'(beat.x_value));
		hist_x[next_slot] = beat.x_value;
		hist_y[next_slot] = beat.y_value;
		next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
		if (depth < WINDOW)
			depth++;
		if (depth < WINDOW)
			return;

		num = longint'(WINDOW) * longint'(run_xy) - longint'(run_x) * longint'(run_y);
		den = longint'(WINDOW) * longint'(run_xx) - longint'(run_x) * longint'(run_x);
		r = '0;
		if (den <= 0) begin
			r.degenerate = 1'b1;
		end else begin
			neg = num < 0;
			sat = 1'b0;
			mag = neg ? -num : num;
			dmag = den;
			quo = mag / dmag;
			rem = mag % dmag;
			if (quo > 32768) begin
				sat = 1'b1;
				lo = neg ? SLOPE_MIN : SLOPE_MAX;
			end else begin
				fixed = (quo << FRAC_W) | ((rem << FRAC_W) / dmag);
				if (!neg && fixed > SLOPE_MAX) begin
					sat = 1'b1;
					fixed = 64'(SLOPE_MAX);
				end else if (neg && fixed > SLOPE_MIN) begin
					sat = 1'b1;
					fixed = 64'(SLOPE_MIN);
				end
				lo = fixed[SLOPE_W-1:0];
				if (neg)
					lo = -lo;
			end
			r.slope_out = lo;
			r.saturated = sat;
		end
		slope_due = {slope_due, r};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			clear_sums();
			slope_due.delete();
			errors = 0;
			pending = 0;
			results = 0;
			degenerate_cnt = 0;
			saturated_cnt = 0;
		end else begin
			// compare before taking the input beat of the same edge
			if (out_valid && out_ready) begin
				results++;
				degenerate_cnt += out_data.degenerate;
				saturated_cnt += out_data.saturated;
				if (slope_due.size() == 0) begin
					$display("%0t: unexpected result beat: slope %h degenerate %b saturated %b",
						$time, out_data.slope_out, out_data.degenerate, out_data.saturated);
					errors++;
				end else begin
					want = slope_due.pop_front();
					if (out_data !== want) begin
						$display("%0t: expected slope %h degenerate %b saturated %b, got slope %h degenerate %b saturated %b",
							$time, want.slope_out, want.degenerate, want.saturated,
							out_data.slope_out, out_data.degenerate, out_data.saturated);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				advance_window_slope(in_data);
			pending = slope_due.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for sliding_window_lsq_slope: clock, reset, sample profiles with
// random gaps and output stalls, and the final verdict. Uses swlsq_checker.
module tb_top
	import swlsq_pkg::*;
();

	localparam int N_ITEMS = 900;
	localparam logic signed [X_W-1:0] X_LO = 16'sh8000;
	localparam logic signed [X_W-1:0] X_HI = 16'sh7FFF;
	localparam logic signed [Y_W-1:0] Y_LO = 24'sh800000;
	localparam logic signed [Y_W-1:0] Y_HI = 24'sh7FFFFF;
	localparam longint STEEP [4] = '{-32768, 32768, -32767, 32767};

	typedef enum int {
		P_LINEAR, P_STEEP_EXACT, P_FLAT_X, P_ONE_STEP, P_NARROW_X, P_NOISE
	} shape_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready;
	logic out_valid, out_ready;
	in_t  in_data;
	out_t out_data;
	int   errors, pending, results, degenerate_cnt, saturated_cnt;
	int   sent;
	int   steep_turn;
	bit   gaps_on;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sliding_window_lsq_slope u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	swlsq_checker #(.WINDOW(WINDOW_DEF)) u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.errors        (errors),
		.pending       (pending),
		.results       (results),
		.degenerate_cnt(degenerate_cnt),
		.saturated_cnt (saturated_cnt)
	);

	function automatic logic signed [X_W-1:0] rand_x();
		return 16'($urandom);
	endfunction

	function automatic logic signed [Y_W-1:0] rand_y();
		return 24'($urandom);
	endfunction

	function automatic logic signed [Y_W-1:0] clip_y(longint v);
		if (v > longint'(Y_HI))
			return Y_HI;
		if (v < longint'(Y_LO))
			return Y_LO;
		return v[Y_W-1:0];
	endfunction

	// Present one beat, with an optional gap before it, and hold until accepted.
	task automatic send_sample(input logic signed [X_W-1:0] x, input logic signed [Y_W-1:0] y,
		input logic np);
		in_t beat;
		beat.x_value = x;
		beat.y_value = y;
		beat.new_profile = np;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// One profile: samples of the given shape, the first one flagged as a new profile.
	// Some profiles are cut short before the window fills.
	task automatic run_profile(input shape_t shape);
		int     len, i;
		longint x0, dx, k, nz, steep, xv, yv;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, WINDOW_DEF - 1)
			: WINDOW_DEF + $urandom_range(0, 25);
		x0 = longint'($urandom_range(0, 2000)) - 1000;
		dx = $urandom_range(1, 300);
		k = $urandom_range(0, 1 << $urandom_range(0, 16));
		if ($urandom_range(0, 1))
			k = -k;
		nz = $urandom_range(0, 1 << $urandom_range(0, 12));
		steep = STEEP[steep_turn % 4];
		if (shape == P_STEEP_EXACT)
			steep_turn++;
		for (i = 0; i < len; i++) begin
			case (shape)
				P_LINEAR: begin
					xv = x0 + i * dx;
					yv = k * xv + longint'($urandom_range(0, 2 * nz)) - nz;
				end
				P_STEEP_EXACT: begin
					xv = i - 10;
					yv = steep * xv;
				end
				P_FLAT_X: begin
					xv = x0;
					yv = rand_y();
				end
				P_ONE_STEP: begin
					xv = x0 + ((i % 7 == 3) ? 1 : 0);
					yv = $urandom_range(0, 1) ? longint'(Y_HI) : longint'(Y_LO);
				end
				P_NARROW_X: begin
					xv = x0 + $urandom_range(0, 3);
					yv = rand_y();
				end
				default: begin
					xv = rand_x();
					yv = rand_y();
				end
			endcase
			send_sample(xv[X_W-1:0], clip_y(yv), i == 0);
		end
	endtask

	// Output side: ready bursts with random stalls while gaps are on.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		int i, pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		sent = 0;
		steep_turn = 0;
		gaps_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Constant x fills the window: zero denominator. A single step in x with
		// extreme y then drives the slope far out of range, then field extremes.
		for (i = 0; i < WINDOW_DEF; i++)
			send_sample(16'sd5, Y_LO, i == 0);
		send_sample(16'sd6, Y_HI, 1'b0);
		send_sample(X_LO, Y_HI, 1'b0);
		send_sample(X_HI, Y_LO, 1'b0);
		send_sample(-16'sd1, -24'sd1, 1'b0);

		while (sent < N_ITEMS) begin
			if (sent >= N_ITEMS - 150)
				gaps_on = 1'b0;
			pick = $urandom_range(0, 9);
			if (pick >= 8)
				repeat ($urandom_range(1, 30))
					send_sample(rand_x(), rand_y(), $urandom_range(0, 63) == 0);
			else if (pick >= 6)
				run_profile(P_STEEP_EXACT);
			else
				run_profile(shape_t'(pick));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Run covered %0d input beats and %0d slope results,", sent, results);
		$display("of which %0d degenerate and %0d saturated.", degenerate_cnt, saturated_cnt);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- sliding_window_lsq_slope.f -----
+incdir+hdl
hdl/swlsq_pkg.sv
hdl/sliding_window_lsq_slope.sv
hdl/swlsq_check.sv
tb/sv/swlsq_checker.sv
tb/sv/tb_top.sv
